// ===== hw/rtl/ypr_pkg.sv =====
package ypr_pkg;

	// Configuration port
	localparam int CFG_IDX_W   = 8;
	localparam int ANGLE_REG_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_YAW   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PITCH = CFG_IDX_W'(1);

	// Basis arithmetic: unsigned Q2.62 words and their full products
	localparam int Q_W = 64;

	typedef logic [Q_W-1:0]   q62_t;
	typedef logic [2*Q_W-1:0] wide_t;

	localparam q62_t ONE_Q62 = 64'h4000_0000_0000_0000;
	localparam q62_t PI_Q62  = 64'hC90F_DAA2_2168_C235;

	// Taylor series length for sine and cosine
	localparam int SERIES_TERMS = 26;
	localparam int TERM_W       = $clog2(SERIES_TERMS + 1);

	typedef logic [TERM_W-1:0] term_idx_t;

endpackage

// ===== hw/rtl/ypr_mul64.sv =====
// 64 x 64 unsigned multiply on one 32 x 32 multiplier, one partial product a cycle.
// A start pulse latches the operands; done pulses with the product once all four partial products are summed.
module ypr_mul64 (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  ypr_pkg::q62_t a,
	input  ypr_pkg::q62_t b,
	output logic          done,
	output ypr_pkg::wide_t prod
);
	import ypr_pkg::*;

	localparam int          HALF_W    = Q_W / 2;
	localparam logic [2:0]  PART_LAST = 3'd4;

	q62_t              a_q;
	q62_t              b_q;
	q62_t              pp_q;
	wide_t             acc_q;
	logic [2:0]        cnt_q;
	logic              run_q;
	logic              done_q;
	logic [HALF_W-1:0] op_x;
	logic [HALF_W-1:0] op_y;
	wide_t             addend;

	// Pick the operand halves for this cycle's partial product
	always_comb begin
		case (cnt_q)
			3'd0: begin
				op_x = a_q[HALF_W-1:0];
				op_y = b_q[HALF_W-1:0];
			end
			3'd1: begin
				op_x = a_q[HALF_W-1:0];
				op_y = b_q[Q_W-1:HALF_W];
			end
			3'd2: begin
				op_x = a_q[Q_W-1:HALF_W];
				op_y = b_q[HALF_W-1:0];
			end
			default: begin
				op_x = a_q[Q_W-1:HALF_W];
				op_y = b_q[Q_W-1:HALF_W];
			end
		endcase
	end

	// Align the previous cycle's partial product
	always_comb begin
		case (cnt_q)
			3'd1:       addend = wide_t'(pp_q);
			3'd2, 3'd3: addend = wide_t'(pp_q) << HALF_W;
			3'd4:       addend = wide_t'(pp_q) << Q_W;
			default:    addend = '0;
		endcase
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == PART_LAST) && !start;
			if (start) begin
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == PART_LAST)
					run_q <= 1'b0;
			end
		end
	end

	// Operands, partial product and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (run_q) begin
			if (cnt_q != PART_LAST)
				pp_q <= Q_W'(op_x) * Q_W'(op_y);
			acc_q <= acc_q + addend;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ===== hw/rtl/ypr_basis.sv =====
// Rotation basis sequencer: sine and cosine of yaw and pitch by a Taylor series in Q2.62,
// the four cross products, with every computed entry rounded to Q1.COEF_FRAC_BITS.
module ypr_basis #(
	parameter int COEF_FRAC_BITS = 16,
	parameter int ANGLE_BITS     = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      go,
	input  logic signed [ypr_pkg::ANGLE_REG_W-1:0]    yaw,
	input  logic signed [ypr_pkg::ANGLE_REG_W-1:0]    pitch,
	output logic                                      busy,
	output logic signed [COEF_FRAC_BITS+1:0]          coef [9]
);
	import ypr_pkg::*;

	localparam int CW       = COEF_FRAC_BITS + 2;
	localparam int QTR_W    = ANGLE_BITS - 2;
	localparam int QUARTER  = 1 << QTR_W;
	localparam int HALF_QTR = 1 << (QTR_W - 1);
	localparam int EXT_W    = (ANGLE_BITS > ANGLE_REG_W) ? ANGLE_BITS : ANGLE_REG_W;
	localparam int DIV_W    = $clog2(Q_W);

	localparam logic [DIV_W-1:0]     DIV_LAST = DIV_W'(Q_W - 1);
	localparam term_idx_t            N_LAST   = TERM_W'(SERIES_TERMS);
	localparam logic signed [CW-1:0] COEF_ONE = CW'(longint'(1) << COEF_FRAC_BITS);

	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;

	localparam logic [1:0] PK_SYSP = 2'd0;
	localparam logic [1:0] PK_SYCP = 2'd1;
	localparam logic [1:0] PK_CYSP = 2'd2;
	localparam logic [1:0] PK_CYCP = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_XWAIT,
		ST_TWAIT,
		ST_DIV,
		ST_ACC,
		ST_FIN,
		ST_PMUL,
		ST_PWAIT
	} state_t;

	function automatic logic signed [CW-1:0] to_coef(input logic signed [Q_W-1:0] v);
		q62_t mag;
		q62_t rnd;
		mag = v[Q_W-1] ? q62_t'(-v) : q62_t'(v);
		rnd = (mag + (q62_t'(1) << (61 - COEF_FRAC_BITS))) >> (62 - COEF_FRAC_BITS);
		return v[Q_W-1] ? -$signed(rnd[CW-1:0]) : $signed(rnd[CW-1:0]);
	endfunction

	state_t                  state_q;
	logic                    ang_sel_q;
	term_idx_t               n_q;
	logic [DIV_W-1:0]        div_cnt_q;
	logic [1:0]              prod_k_q;
	logic                    mul_start_q;
	logic signed [CW-1:0]    coef_q [9];

	logic [1:0]              quad_q;
	logic                    swap_q;
	q62_t                    x_q;
	q62_t                    sn_q;
	q62_t                    cs_q;
	term_idx_t               div_rem_q;
	q62_t                    div_quo_q;
	logic signed [Q_W-1:0]   sy_q;
	logic signed [Q_W-1:0]   cy_q;
	logic signed [Q_W-1:0]   sp_q;
	logic signed [Q_W-1:0]   cp_q;
	logic                    neg_q;
	q62_t                    mul_a_q;
	q62_t                    mul_b_q;

	logic                    mul_done;
	wide_t                   mul_prod;

	logic signed [ANGLE_REG_W-1:0] ang_cur;
	logic [EXT_W-1:0]        ang_ext;
	logic [ANGLE_BITS-1:0]   turn;
	logic [QTR_W-1:0]        r_raw;
	logic [QTR_W:0]          r_diff;
	logic                    swap_n;
	logic [QTR_W-1:0]        r_red;
	q62_t                    x_n;
	q62_t                    t_n;
	logic [TERM_W:0]         div_trial;
	logic [TERM_W:0]         div_sub;
	logic                    div_ge;
	logic signed [Q_W-1:0]   s0;
	logic signed [Q_W-1:0]   c0;
	logic signed [Q_W-1:0]   sin_f;
	logic signed [Q_W-1:0]   cos_f;
	logic signed [Q_W-1:0]   pa;
	logic signed [Q_W-1:0]   pb;
	q62_t                    mag_a;
	q62_t                    mag_b;
	logic signed [Q_W-1:0]   prod_m;
	logic signed [Q_W-1:0]   prod_v;
	logic signed [CW-1:0]    tc_s;
	logic signed [CW-1:0]    tc_c;
	logic signed [CW-1:0]    tc_p;

	ypr_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// Reduce the angle to a quadrant and an octant-folded residue
	always_comb begin
		ang_cur = ang_sel_q ? pitch : yaw;
		ang_ext = EXT_W'(ang_cur);
		turn    = ang_ext[ANGLE_BITS-1:0];
		r_raw   = turn[QTR_W-1:0];
		swap_n  = r_raw > QTR_W'(HALF_QTR);
		r_diff  = (QTR_W + 1)'(QUARTER) - (QTR_W + 1)'(r_raw);
		r_red   = swap_n ? r_diff[QTR_W-1:0] : r_raw;
	end

	// Product slices: angle in radians, and Q62 products
	assign x_n = mul_prod[ANGLE_BITS+Q_W-2:ANGLE_BITS-1];
	assign t_n = mul_prod[2*Q_W-3:Q_W-2];

	// One restoring division step by the term index
	always_comb begin
		div_trial = {div_rem_q, div_quo_q[Q_W-1]};
		div_ge    = div_trial >= {1'b0, n_q};
		div_sub   = div_trial - {1'b0, n_q};
	end

	// Undo the fold and place the quadrant
	always_comb begin
		s0 = swap_q ? $signed(cs_q) : $signed(sn_q);
		c0 = swap_q ? $signed(sn_q) : $signed(cs_q);
		case (quad_q)
			QUAD_I: begin
				sin_f = s0;
				cos_f = c0;
			end
			QUAD_II: begin
				sin_f = c0;
				cos_f = -s0;
			end
			QUAD_III: begin
				sin_f = -s0;
				cos_f = -c0;
			end
			default: begin
				sin_f = -c0;
				cos_f = s0;
			end
		endcase
	end

	// Cross product operands as sign and magnitude
	always_comb begin
		pa     = prod_k_q[1] ? cy_q : sy_q;
		pb     = prod_k_q[0] ? cp_q : sp_q;
		mag_a  = pa[Q_W-1] ? q62_t'(-pa) : q62_t'(pa);
		mag_b  = pb[Q_W-1] ? q62_t'(-pb) : q62_t'(pb);
		prod_m = $signed(t_n);
		prod_v = neg_q ? -prod_m : prod_m;
		tc_s   = to_coef(sin_f);
		tc_c   = to_coef(cos_f);
		tc_p   = to_coef(prod_v);
	end

	// Sequencer state, counters and the held matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ang_sel_q   <= 1'b0;
			n_q         <= '0;
			div_cnt_q   <= '0;
			prod_k_q    <= PK_SYSP;
			mul_start_q <= 1'b0;
			for (int i = 0; i < 9; i++)
				coef_q[i] <= '0;
			coef_q[0] <= COEF_ONE;
			coef_q[4] <= COEF_ONE;
			coef_q[8] <= COEF_ONE;
		end else begin
			mul_start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (go) begin
						ang_sel_q <= 1'b0;
						state_q   <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					mul_start_q <= 1'b1;
					state_q     <= ST_XWAIT;
				end
				ST_XWAIT: begin
					if (mul_done) begin
						n_q         <= TERM_W'(1);
						mul_start_q <= 1'b1;
						state_q     <= ST_TWAIT;
					end
				end
				ST_TWAIT: begin
					if (mul_done) begin
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + DIV_W'(1);
					if (div_cnt_q == DIV_LAST)
						state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (n_q == N_LAST) begin
						state_q <= ST_FIN;
					end else begin
						n_q         <= n_q + TERM_W'(1);
						mul_start_q <= 1'b1;
						state_q     <= ST_TWAIT;
					end
				end
				ST_FIN: begin
					if (!ang_sel_q) begin
						// yaw: cy and sy entries, then pitch
						coef_q[0] <= tc_c;
						coef_q[6] <= tc_s;
						ang_sel_q <= 1'b1;
						state_q   <= ST_SETUP;
					end else begin
						coef_q[4] <= tc_c;
						coef_q[5] <= tc_s;
						prod_k_q  <= PK_SYSP;
						state_q   <= ST_PMUL;
					end
				end
				ST_PMUL: begin
					mul_start_q <= 1'b1;
					state_q     <= ST_PWAIT;
				end
				ST_PWAIT: begin
					if (mul_done) begin
						case (prod_k_q)
							PK_SYSP: coef_q[1] <= tc_p;
							PK_SYCP: coef_q[2] <= -tc_p;
							PK_CYSP: coef_q[7] <= -tc_p;
							default: coef_q[8] <= tc_p;
						endcase
						if (prod_k_q == PK_CYCP) begin
							state_q <= ST_IDLE;
						end else begin
							prod_k_q <= prod_k_q + 2'd1;
							state_q  <= ST_PMUL;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Series datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_SETUP: begin
				quad_q  <= turn[ANGLE_BITS-1 -: 2];
				swap_q  <= swap_n;
				mul_a_q <= PI_Q62;
				mul_b_q <= q62_t'(r_red);
			end
			ST_XWAIT: begin
				if (mul_done) begin
					x_q     <= x_n;
					sn_q    <= '0;
					cs_q    <= ONE_Q62;
					mul_a_q <= ONE_Q62;
					mul_b_q <= x_n;
				end
			end
			ST_TWAIT: begin
				if (mul_done) begin
					div_quo_q <= t_n;
					div_rem_q <= '0;
				end
			end
			ST_DIV: begin
				div_rem_q <= div_ge ? div_sub[TERM_W-1:0] : div_trial[TERM_W-1:0];
				div_quo_q <= {div_quo_q[Q_W-2:0], div_ge};
			end
			ST_ACC: begin
				// odd terms build the sine, even the cosine; sign flips every second term
				if (n_q[0])
					sn_q <= n_q[1] ? sn_q - div_quo_q : sn_q + div_quo_q;
				else
					cs_q <= n_q[1] ? cs_q - div_quo_q : cs_q + div_quo_q;
				mul_a_q <= div_quo_q;
				mul_b_q <= x_q;
			end
			ST_FIN: begin
				if (!ang_sel_q) begin
					sy_q <= sin_f;
					cy_q <= cos_f;
				end else begin
					sp_q <= sin_f;
					cp_q <= cos_f;
				end
			end
			ST_PMUL: begin
				mul_a_q <= mag_a;
				mul_b_q <= mag_b;
				neg_q   <= pa[Q_W-1] ^ pb[Q_W-1];
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign coef = coef_q;

endmodule

// ===== hw/rtl/ypr_xform.sv =====
// Point transform pipeline: products, partial row sums, full row sums, saturation.
module ypr_xform #(
	parameter int COORD_WIDTH    = 32,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic signed [COORD_WIDTH-1:0]   point_x,
	input  logic signed [COORD_WIDTH-1:0]   point_y,
	input  logic signed [COORD_WIDTH-1:0]   point_z,
	input  logic signed [COEF_FRAC_BITS+1:0] coef [9],
	output logic                            out_valid,
	output logic signed [COORD_WIDTH-1:0]   world_x,
	output logic signed [COORD_WIDTH-1:0]   world_y,
	output logic signed [COORD_WIDTH-1:0]   world_z
);

	localparam int CW = COEF_FRAC_BITS + 2;
	localparam int PW = CW + COORD_WIDTH;
	localparam int TW = COORD_WIDTH + 2;
	localparam int SW = COORD_WIDTH + 4;

	function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
		logic [SW-COORD_WIDTH:0] top_bits;
		top_bits = v[SW-1:COORD_WIDTH-1];
		if ((&top_bits) || !(|top_bits))
			return v[COORD_WIDTH-1:0];
		else if (v[SW-1])
			return {1'b1, {(COORD_WIDTH - 1){1'b0}}};
		return {1'b0, {(COORD_WIDTH - 1){1'b1}}};
	endfunction

	logic signed [COORD_WIDTH-1:0] pt [3];
	logic signed [PW-1:0]          prod_s1 [9];
	logic signed [SW-1:0]          part_s2 [3];
	logic signed [TW-1:0]          third_s2 [3];
	logic signed [SW-1:0]          sum_s3 [3];
	logic signed [COORD_WIDTH-1:0] world_s4 [3];
	logic                          v_s1;
	logic                          v_s2;
	logic                          v_s3;
	logic                          v_s4;

	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Multiply, floor-shift and sum each row, then clamp
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++)
				prod_s1[r*3+c] <= PW'(coef[r*3+c]) * PW'(pt[c]);
			part_s2[r]  <= SW'(TW'(prod_s1[r*3] >>> COEF_FRAC_BITS))
				+ SW'(TW'(prod_s1[r*3+1] >>> COEF_FRAC_BITS));
			third_s2[r] <= TW'(prod_s1[r*3+2] >>> COEF_FRAC_BITS);
			sum_s3[r]   <= part_s2[r] + SW'(third_s2[r]);
			world_s4[r] <= sat(sum_s3[r]);
		end
	end

	assign out_valid = v_s4;
	assign world_x   = world_s4[0];
	assign world_y   = world_s4[1];
	assign world_z   = world_s4[2];

endmodule

// ===== hw/rtl/yaw_pitch_point_rotation.sv =====
// Channel   Handshake              Word
// point     start / busy           point_x, point_y, point_z
// world     done (strobe)          world_x, world_y, world_z
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A point is taken when start is high and busy is low, one per cycle at full rate.
// Its result shows on done after the four-stage multiply-add pipeline.
// An angle write rebuilds the basis on one shared 32x32 multiplier and a bit-serial divider:
// busy stays high and cfg_ready low while the series runs for both angles.
// Reset gives zero angles and the identity basis at once, with busy low.
// Results are never held back: each word is on the ports for exactly the done cycle.
module yaw_pitch_point_rotation #(
	parameter int COORD_WIDTH    = 32,
	parameter int COEF_FRAC_BITS = 16,
	parameter int ANGLE_BITS     = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [COORD_WIDTH-1:0]          point_x,
	input  logic signed [COORD_WIDTH-1:0]          point_y,
	input  logic signed [COORD_WIDTH-1:0]          point_z,
	output logic                                   done,
	output logic signed [COORD_WIDTH-1:0]          world_x,
	output logic signed [COORD_WIDTH-1:0]          world_y,
	output logic signed [COORD_WIDTH-1:0]          world_z,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [ypr_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [ypr_pkg::ANGLE_REG_W-1:0]        cfg_data
);
	import ypr_pkg::*;

	localparam int CW = COEF_FRAC_BITS + 2;

	logic signed [ANGLE_REG_W-1:0] yaw_q;
	logic signed [ANGLE_REG_W-1:0] pitch_q;
	logic                          cfg_we;
	logic                          rebuild;
	logic                          accept;
	logic                          basis_busy;
	logic signed [CW-1:0]          coef [9];

	assign cfg_ready = !basis_busy;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign busy      = basis_busy;
	assign accept    = start && !basis_busy;

	// Decode a register write; unknown indexes are dropped
	always_comb begin
		case (cfg_index)
			REG_YAW, REG_PITCH: rebuild = cfg_we;
			default:            rebuild = 1'b0;
		endcase
	end

	// Hold the angle registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_q   <= '0;
			pitch_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_YAW:   yaw_q   <= $signed(cfg_data);
				REG_PITCH: pitch_q <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

	ypr_basis #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.ANGLE_BITS     (ANGLE_BITS)
	) u_basis (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (rebuild),
		.yaw    (yaw_q),
		.pitch  (pitch_q),
		.busy   (basis_busy),
		.coef   (coef)
	);

	ypr_xform #(
		.COORD_WIDTH    (COORD_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.coef      (coef),
		.out_valid (done),
		.world_x   (world_x),
		.world_y   (world_y),
		.world_z   (world_z)
	);

	// Every accepted point comes out on done at the end of the pipeline
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("accepted point produced no result");

	// An angle write starts a rebuild
	a_rebuild_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && (cfg_index == REG_YAW || cfg_index == REG_PITCH)) |=> busy)
		else $error("angle write did not start basis rebuild");

	// Busy only rises after a register write
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(cfg_we))
		else $error("busy rose without a register write");

endmodule
